// ----- sv/lbt_pkg.sv -----
// Shared types, codes and constants of the listen-before-talk transmit controller.
package lbt_pkg;

	// width of time values; they wrap at this width
	localparam int TimeW = 32;

	// command word queue between front and back
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// register reset values
	localparam logic [15:0] CadTimeoutRst = 16'd100;
	localparam logic [15:0] TxTimeoutRst  = 16'd2000;
	localparam logic [3:0]  MaxAttRst     = 4'd3;

	// register indexes
	localparam logic [1:0] REG_CAD_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_TX_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_MAX_ATT     = 2'd2;

	// command codes on the input
	localparam logic [2:0] CMD_START    = 3'd0;
	localparam logic [2:0] CMD_TICK     = 3'd1;
	localparam logic [2:0] CMD_DET_DONE = 3'd2;
	localparam logic [2:0] CMD_TX_DONE  = 3'd3;
	localparam logic [2:0] CMD_SET_MODE = 3'd4;
	localparam logic [2:0] CMD_CLEAR    = 3'd5;

	// radio modes
	localparam logic [2:0] MODE_SLEEP   = 3'd0;
	localparam logic [2:0] MODE_STANDBY = 3'd1;
	localparam logic [2:0] MODE_TX      = 3'd3;
	localparam logic [2:0] MODE_RXCONT  = 3'd5;
	localparam logic [2:0] MODE_DETECT  = 3'd7;

	// actions
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_STANDBY   = 3'd1;
	localparam logic [2:0] ACT_DETECT    = 3'd2;
	localparam logic [2:0] ACT_TX        = 3'd3;
	localparam logic [2:0] ACT_RXRESTART = 3'd4;
	localparam logic [2:0] ACT_SETMODE   = 3'd5;

	// status codes
	localparam logic [2:0] ST_PENDING  = 3'd0;
	localparam logic [2:0] ST_OK       = 3'd1;
	localparam logic [2:0] ST_TIMEOUT  = 3'd2;
	localparam logic [2:0] ST_BUSY     = 3'd3;
	localparam logic [2:0] ST_INVALID  = 3'd4;
	localparam logic [2:0] ST_REJECTED = 3'd5;

	// input word
	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] budget_ms;
		logic [7:0]  byte_count;
		logic        channel_busy;
		logic [2:0]  mode_value;
	} in_t;

	// result word
	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  action_mode;
		logic [2:0]  status;
		logic        last;
		logic [31:0] ok_count;
		logic [31:0] fail_count;
		logic [31:0] busy_count;
	} res_t;

	// command class decided by the front end
	typedef enum logic [2:0] {
		K_START,
		K_TICK,
		K_DET_DONE,
		K_TX_DONE,
		K_SET_MODE,
		K_CLEAR,
		K_OTHER
	} kind_t;

	// classified command as queued for the back end
	typedef struct packed {
		kind_t             kind;
		logic [TimeW-1:0]  timeout;
		logic              len_zero;
		logic              channel_busy;
		logic [2:0]        mode_value;
	} cmd_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [15:0] cad_timeout_ms;
		logic [15:0] default_tx_timeout_ms;
		logic [3:0]  max_attempts;
	} cfg_t;

	// queue head towards the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

// ----- sv/lbt_front.sv -----
// Front end: takes input words and classifies them into queued commands.
module lbt_front (
	input  lbt_pkg::in_t  item,
	output lbt_pkg::cmd_t cmd
);

	// decode the command code and pass the operands on
	always_comb begin
		unique case (item.command)
			lbt_pkg::CMD_START:    cmd.kind = lbt_pkg::K_START;
			lbt_pkg::CMD_TICK:     cmd.kind = lbt_pkg::K_TICK;
			lbt_pkg::CMD_DET_DONE: cmd.kind = lbt_pkg::K_DET_DONE;
			lbt_pkg::CMD_TX_DONE:  cmd.kind = lbt_pkg::K_TX_DONE;
			lbt_pkg::CMD_SET_MODE: cmd.kind = lbt_pkg::K_SET_MODE;
			lbt_pkg::CMD_CLEAR:    cmd.kind = lbt_pkg::K_CLEAR;
			default:               cmd.kind = lbt_pkg::K_OTHER;
		endcase

		// operands, time budget brought to the time width
		cmd.timeout      = lbt_pkg::TimeW'(item.budget_ms);
		cmd.len_zero     = (item.byte_count == 8'd0);
		cmd.channel_busy = item.channel_busy;
		cmd.mode_value   = item.mode_value;
	end

endmodule

// ----- sv/lbt_queue.sv -----
// Short command queue between the front and back ends.
module lbt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  lbt_pkg::cmd_t   wr_cmd,
	output logic            full,
	input  logic            rd_en,
	output lbt_pkg::head_t  head
);

	lbt_pkg::cmd_t                mem_q [lbt_pkg::QDepth];
	logic [lbt_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [lbt_pkg::QCntW-1:0]    cnt_q;
	logic                         do_wr, do_rd;

	assign full       = (cnt_q == lbt_pkg::QCntW'(lbt_pkg::QDepth));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_wr      = wr_en && !full;
	assign do_rd      = rd_en && head.valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- sv/lbt_exec.sv -----
// Back end: sequencer state, counters and the two-word result buffer.
module lbt_exec (
	input  logic            clk,
	input  logic            arst_n,
	input  lbt_pkg::cfg_t   cfg,
	input  lbt_pkg::head_t  head,
	output logic            head_pop,
	output logic            empty,
	input  logic            pop,
	output lbt_pkg::res_t   result
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DETECT,
		PH_TX
	} phase_t;

	phase_t                      phase_q, phase_n;
	logic [3:0]                  attempt_q, attempt_n;
	logic [lbt_pkg::TimeW-1:0]   now_q, now_n;
	logic [lbt_pkg::TimeW-1:0]   deadline_q, deadline_n;
	logic [lbt_pkg::TimeW-1:0]   pstart_q, pstart_n;
	logic [lbt_pkg::TimeW-1:0]   txlim_q, txlim_n;
	logic [2:0]                  cur_mode_q, cur_mode_n;
	logic [2:0]                  prior_mode_q, prior_mode_n;
	logic [31:0]                 ok_q, ok_n, fail_q, fail_n, busy_q, busy_n;

	// result buffer: two slots, count of words left, slot on the port
	lbt_pkg::res_t     res0_q, res1_q, r0, r1;
	logic [1:0]        cnt_q;
	logic              sel_q;
	logic              two;

	logic [lbt_pkg::TimeW-1:0]   tick_now, elapsed, start_dl, remain;
	logic              load, popped;

	lbt_pkg::cmd_t     c;

	assign c      = head.cmd;
	assign popped = pop && !empty;
	assign load   = head.valid && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && popped));
	assign head_pop = load;
	assign empty  = (cnt_q == 2'd0);
	assign result = sel_q ? res1_q : res0_q;

	assign tick_now = now_q + 1'b1;
	assign elapsed  = tick_now - pstart_q;
	assign start_dl = now_q + c.timeout;
	assign remain   = deadline_q - now_q;

	// command execution
	always_comb begin
		phase_n      = phase_q;
		attempt_n    = attempt_q;
		now_n        = now_q;
		deadline_n   = deadline_q;
		pstart_n     = pstart_q;
		txlim_n      = txlim_q;
		cur_mode_n   = cur_mode_q;
		prior_mode_n = prior_mode_q;
		ok_n         = ok_q;
		fail_n       = fail_q;
		busy_n       = busy_q;
		two          = 1'b0;
		r0           = '0;
		r1           = '0;
		r0.action    = lbt_pkg::ACT_NONE;
		r0.status    = lbt_pkg::ST_PENDING;

		unique case (c.kind)
			lbt_pkg::K_START: begin
				if (phase_q != PH_IDLE) begin
					r0.status = lbt_pkg::ST_REJECTED;
				end else if (c.len_zero) begin
					r0.status = lbt_pkg::ST_INVALID;
				end else begin
					deadline_n = start_dl;
					if (now_q >= start_dl) begin
						// budget already spent
						attempt_n = 4'd0;
						fail_n    = fail_q + 1'b1;
						r0.status = lbt_pkg::ST_TIMEOUT;
					end else begin
						prior_mode_n   = cur_mode_q;
						cur_mode_n     = lbt_pkg::MODE_DETECT;
						attempt_n      = 4'd1;
						phase_n        = PH_DETECT;
						pstart_n       = now_q;
						r0.action      = lbt_pkg::ACT_DETECT;
						r0.action_mode = lbt_pkg::MODE_DETECT;
					end
				end
			end
			lbt_pkg::K_TICK: begin
				now_n = tick_now;
				if ((phase_q == PH_DETECT &&
				     elapsed > lbt_pkg::TimeW'(cfg.cad_timeout_ms)) ||
				    (phase_q == PH_TX && elapsed > txlim_q)) begin
					fail_n         = fail_q + 1'b1;
					cur_mode_n     = lbt_pkg::MODE_STANDBY;
					phase_n        = PH_IDLE;
					r0.action      = lbt_pkg::ACT_STANDBY;
					r0.action_mode = lbt_pkg::MODE_STANDBY;
					r0.status      = lbt_pkg::ST_TIMEOUT;
				end
			end
			lbt_pkg::K_DET_DONE: begin
				if (phase_q == PH_DETECT) begin
					cur_mode_n     = lbt_pkg::MODE_STANDBY;
					r0.action      = lbt_pkg::ACT_STANDBY;
					r0.action_mode = lbt_pkg::MODE_STANDBY;
					if (c.channel_busy) begin
						priority if (attempt_q >= cfg.max_attempts) begin
							// out of attempts: detection and give-up both count
							busy_n    = busy_q + 32'd2;
							phase_n   = PH_IDLE;
							r0.status = lbt_pkg::ST_BUSY;
						end else if (now_q >= deadline_q) begin
							busy_n    = busy_q + 1'b1;
							fail_n    = fail_q + 1'b1;
							phase_n   = PH_IDLE;
							r0.status = lbt_pkg::ST_TIMEOUT;
						end else begin
							// retry; the mode to restore is now standby
							busy_n         = busy_q + 1'b1;
							prior_mode_n   = lbt_pkg::MODE_STANDBY;
							cur_mode_n     = lbt_pkg::MODE_DETECT;
							attempt_n      = attempt_q + 1'b1;
							pstart_n       = now_q;
							two            = 1'b1;
							r1.action      = lbt_pkg::ACT_DETECT;
							r1.action_mode = lbt_pkg::MODE_DETECT;
							r1.status      = lbt_pkg::ST_PENDING;
						end
					end else begin
						// channel free: transmit within what is left of the budget, else the default limit
						txlim_n        = (remain != '0) ? remain :
						                 lbt_pkg::TimeW'(cfg.default_tx_timeout_ms);
						cur_mode_n     = lbt_pkg::MODE_TX;
						phase_n        = PH_TX;
						pstart_n       = now_q;
						two            = 1'b1;
						r1.action      = lbt_pkg::ACT_TX;
						r1.action_mode = lbt_pkg::MODE_TX;
						r1.status      = lbt_pkg::ST_PENDING;
					end
				end
			end
			lbt_pkg::K_TX_DONE: begin
				if (phase_q == PH_TX) begin
					ok_n           = ok_q + 1'b1;
					phase_n        = PH_IDLE;
					cur_mode_n     = prior_mode_q;
					two            = 1'b1;
					r0.action      = lbt_pkg::ACT_STANDBY;
					r0.action_mode = lbt_pkg::MODE_STANDBY;
					r1.action      = (prior_mode_q == lbt_pkg::MODE_RXCONT) ?
					                 lbt_pkg::ACT_RXRESTART : lbt_pkg::ACT_SETMODE;
					r1.action_mode = prior_mode_q;
					r1.status      = lbt_pkg::ST_OK;
				end
			end
			lbt_pkg::K_SET_MODE: begin
				if (phase_q != PH_IDLE) begin
					r0.status = lbt_pkg::ST_REJECTED;
				end else begin
					cur_mode_n     = c.mode_value;
					r0.action      = lbt_pkg::ACT_SETMODE;
					r0.action_mode = c.mode_value;
					r0.status      = lbt_pkg::ST_OK;
				end
			end
			lbt_pkg::K_CLEAR: begin
				ok_n      = '0;
				fail_n    = '0;
				busy_n    = '0;
				r0.status = lbt_pkg::ST_OK;
			end
			default: begin
			end
		endcase

		// counters after the whole command on every word; last on the final one
		r0.last       = !two;
		r1.last       = 1'b1;
		r0.ok_count   = ok_n;
		r0.fail_count = fail_n;
		r0.busy_count = busy_n;
		r1.ok_count   = ok_n;
		r1.fail_count = fail_n;
		r1.busy_count = busy_n;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			attempt_q    <= '0;
			now_q        <= '0;
			deadline_q   <= '0;
			pstart_q     <= '0;
			txlim_q      <= '0;
			cur_mode_q   <= lbt_pkg::MODE_SLEEP;
			prior_mode_q <= lbt_pkg::MODE_SLEEP;
			ok_q         <= '0;
			fail_q       <= '0;
			busy_q       <= '0;
		end else if (load) begin
			phase_q      <= phase_n;
			attempt_q    <= attempt_n;
			now_q        <= now_n;
			deadline_q   <= deadline_n;
			pstart_q     <= pstart_n;
			txlim_q      <= txlim_n;
			cur_mode_q   <= cur_mode_n;
			prior_mode_q <= prior_mode_n;
			ok_q         <= ok_n;
			fail_q       <= fail_n;
			busy_q       <= busy_n;
		end
	end

	// result slots
	always_ff @(posedge clk) begin
		if (load) begin
			res0_q <= r0;
			res1_q <= r1;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			sel_q <= 1'b0;
		end else if (load) begin
			cnt_q <= two ? 2'd2 : 2'd1;
			sel_q <= 1'b0;
		end else if (popped) begin
			cnt_q <= cnt_q - 1'b1;
			sel_q <= 1'b1;
		end
	end

endmodule

// ----- sv/listen_before_talk_tx_controller.sv -----
// Top level of the listen-before-talk transmit controller: ports, registers, front and back.
//
//  channel   | handshake               | word
//  ----------+-------------------------+---------------------------------------
//  commands  | push / full             | item   (lbt_pkg::in_t)
//  results   | pop / empty             | result (lbt_pkg::res_t)
//  registers | psel penable pwrite ... | pwdata / prdata, 32 bits, paddr[3:2]
//
// One command word is taken per cycle while the four-deep command queue has room.
// The sequencer runs one command per cycle out of the queue while the result buffer
// is drained; a command that gives two result words holds the result buffer for two
// pops. Results are registered and appear in the cycle after the back end takes a command.
// Reset clears the queue, the sequencer state, the counters and loads register defaults.
module listen_before_talk_tx_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lbt_pkg::in_t    item,
	output logic            empty,
	input  logic            pop,
	output lbt_pkg::res_t   result,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	lbt_pkg::cfg_t   cfg_q;
	lbt_pkg::cmd_t   front_cmd;
	lbt_pkg::head_t  head;
	logic            head_pop;
	logic            reg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cad_timeout_ms        <= lbt_pkg::CadTimeoutRst;
			cfg_q.default_tx_timeout_ms <= lbt_pkg::TxTimeoutRst;
			cfg_q.max_attempts          <= lbt_pkg::MaxAttRst;
		end else if (reg_wr) begin
			unique case (paddr[3:2])
				lbt_pkg::REG_CAD_TIMEOUT: cfg_q.cad_timeout_ms        <= pwdata[15:0];
				lbt_pkg::REG_TX_TIMEOUT:  cfg_q.default_tx_timeout_ms <= pwdata[15:0];
				lbt_pkg::REG_MAX_ATT:     cfg_q.max_attempts          <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			lbt_pkg::REG_CAD_TIMEOUT: prdata = {16'd0, cfg_q.cad_timeout_ms};
			lbt_pkg::REG_TX_TIMEOUT:  prdata = {16'd0, cfg_q.default_tx_timeout_ms};
			lbt_pkg::REG_MAX_ATT:     prdata = {28'd0, cfg_q.max_attempts};
			default:                  prdata = 32'd0;
		endcase
	end

	// front end: classify incoming words
	lbt_front u_front (
		.item (item),
		.cmd  (front_cmd)
	);

	// command queue
	lbt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_cmd (front_cmd),
		.full   (full),
		.rd_en  (head_pop),
		.head   (head)
	);

	// back end: sequencer and result buffer
	lbt_exec u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.head_pop (head_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
